// ----- hw/rtl/tocb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tocb_pkg
// Shared types and constants for the timed output channel bank.
// ----------------------------------------------------------------------------
package tocb_pkg;

  localparam int unsigned CHANNELS_DEF = 32;
  localparam int unsigned CHAN_W       = 5;
  localparam int unsigned ACTION_W     = 3;
  localparam int unsigned MS_W         = 16;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned STATE_W      = 32;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [MS_W-1:0] DEFAULT_PULSE_RST = MS_W'(100);

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET_STATE = 3'd0,
    ACT_ACTIVATE  = 3'd1,
    ACT_TICK      = 3'd2,
    ACT_CLEAR     = 3'd3,
    ACT_ALL_OFF   = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_DEFAULT_PULSE = 2'd1,
    CFG_MAX_ON        = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  // Write request into the per-channel timer store
  typedef struct packed {
    logic [CHAN_W-1:0] idx;
    logic              on_we;
    logic              set_we;
    logic              pend_we;
    logic              pulse_we;
    logic [TIME_W-1:0] stamp;
    logic [MS_W-1:0]   pend;
    logic [MS_W-1:0]   pulse;
  } chan_wr_t;

  // Timer fields of one channel
  typedef struct packed {
    logic [TIME_W-1:0] on_stamp;
    logic [TIME_W-1:0] set_stamp;
    logic [MS_W-1:0]   pend;
    logic [MS_W-1:0]   pulse;
  } chan_rd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tocb_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tocb_if
// Valid/ready channels of the timed output channel bank: command input,
// result output and register write.
// ----------------------------------------------------------------------------
interface tocb_in_if import tocb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CHAN_W-1:0]   channel;
  logic                turn_on;
  logic [MS_W-1:0]     pulse_ms;
  logic [MS_W-1:0]     delay_ms;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, action, channel, turn_on, pulse_ms, delay_ms, now_ms,
                  input ready);
  modport sink   (input valid, action, channel, turn_on, pulse_ms, delay_ms, now_ms,
                  output ready);
endinterface

interface tocb_out_if import tocb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [STATE_W-1:0] states;
  logic [STATE_W-1:0] change_bits;
  logic [CHAN_W-1:0]  last_changed;

  modport source (output valid, accepted, states, change_bits, last_changed, input ready);
  modport sink   (input valid, accepted, states, change_bits, last_changed, output ready);
endinterface

interface tocb_cfg_if import tocb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tocb_chan_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tocb_chan_store
// Per-channel timer registers: switch-on stamp, last command stamp, pending
// delay and pulse length. One write port with field enables, one read port.
// ----------------------------------------------------------------------------
module tocb_chan_store import tocb_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire chan_wr_t             wr_i,
  input  wire logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] rd_idx_i,
  output chan_rd_t                  rd_o
);

  localparam int unsigned IDX_W = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

  logic [TIME_W-1:0] on_stamp_q  [CHANNELS];
  logic [TIME_W-1:0] set_stamp_q [CHANNELS];
  logic [MS_W-1:0]   pend_q      [CHANNELS];
  logic [MS_W-1:0]   pulse_q     [CHANNELS];
  logic [IDX_W-1:0]  wr_idx;

  assign wr_idx = wr_i.idx[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        on_stamp_q[i]  <= '0;
        set_stamp_q[i] <= '0;
        pend_q[i]      <= '0;
        pulse_q[i]     <= '0;
      end
    end else begin
      if (wr_i.on_we)    on_stamp_q[wr_idx]  <= wr_i.stamp;
      if (wr_i.set_we)   set_stamp_q[wr_idx] <= wr_i.stamp;
      if (wr_i.pend_we)  pend_q[wr_idx]      <= wr_i.pend;
      if (wr_i.pulse_we) pulse_q[wr_idx]     <= wr_i.pulse;
    end
  end

  assign rd_o.on_stamp  = on_stamp_q[rd_idx_i];
  assign rd_o.set_stamp = set_stamp_q[rd_idx_i];
  assign rd_o.pend      = pend_q[rd_idx_i];
  assign rd_o.pulse     = pulse_q[rd_idx_i];

endmodule
`default_nettype wire

// ----- hw/rtl/timed_output_channel_bank_core.sv -----
`default_nettype none
// Results: set_state, activate, clear_changes and unknown actions register
//   their result in the cycle after the input transfer; tick and all_off
//   give it once the scan has visited the channels in use and returned to idle.
// Throughput: one item at a time; the next input is taken once the result
//   transfers. The scan visits one channel per cycle through one subtract/compare.
// Reset: asynchronous, clears control state and timers at once; no clearing pass.
// ----------------------------------------------------------------------------
// timed_output_channel_bank_core
// Bank of timed on/off output channels with delayed switch-on, pulse
// time-out and a shared maximum on time.
// ----------------------------------------------------------------------------
module timed_output_channel_bank_core import tocb_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tocb_in_if.sink    in_i,
  tocb_out_if.source out_o,
  tocb_cfg_if.sink   cfg_i
);

  localparam int unsigned IDX_W = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(CHANNELS + 1);

  // configuration
  logic [CHAN_W-1:0] cnt_cfg_q;
  logic [MS_W-1:0]   dflt_pulse_q;
  logic [TIME_W-1:0] max_on_q;

  // control and bank state
  state_e               state_q, state_d;
  logic [CHANNELS-1:0]  active_q, active_d;
  logic [CHANNELS-1:0]  changed_q, changed_d;
  logic [CHAN_W-1:0]    last_q, last_d;
  logic [CNT_W-1:0]     scan_idx_q, scan_idx_d;
  logic                 scan_off_q, scan_off_d;
  logic                 acc_q, acc_d;
  logic                 out_valid_q, out_valid_d;

  // payload registers
  logic [TIME_W-1:0]    now_q, now_d;
  logic                 out_acc_q, out_acc_d;
  logic [STATE_W-1:0]   out_states_q, out_states_d;
  logic [STATE_W-1:0]   out_change_q, out_change_d;
  logic [CHAN_W-1:0]    out_last_q, out_last_d;

  logic [CNT_W-1:0]     used_cnt;
  logic                 ch_ok;
  logic [IDX_W-1:0]     ch_idx;
  logic [CHANNELS-1:0]  ch_bit;
  logic [IDX_W-1:0]     rd_idx;
  logic [CHANNELS-1:0]  rd_bit;
  logic                 rd_on;
  logic [TIME_W-1:0]    elapsed;
  logic                 in_xfer;
  logic                 out_xfer;
  chan_wr_t             wr;
  chan_rd_t             rd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_cfg_q    <= '0;
      dflt_pulse_q <= DEFAULT_PULSE_RST;
      max_on_q     <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_CHANNEL_COUNT: cnt_cfg_q    <= cfg_i.data[CHAN_W-1:0];
        CFG_DEFAULT_PULSE: dflt_pulse_q <= cfg_i.data[MS_W-1:0];
        CFG_MAX_ON:        max_on_q     <= cfg_i.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign used_cnt = (32'(cnt_cfg_q) < CHANNELS) ? CNT_W'(cnt_cfg_q) : CNT_W'(CHANNELS);
  assign ch_ok    = 32'(in_i.channel) < 32'(used_cnt);
  assign ch_idx   = in_i.channel[IDX_W-1:0];
  assign ch_bit   = CHANNELS'(1) << ch_idx;
  assign rd_idx   = scan_idx_q[IDX_W-1:0];
  assign rd_bit   = CHANNELS'(1) << rd_idx;
  assign rd_on    = active_q[rd_idx];

  assign in_i.ready = (state_q == ST_IDLE) && !out_valid_q;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_valid_q && out_o.ready;

  tocb_chan_store #(
    .CHANNELS (CHANNELS)
  ) u_chan_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_idx_i (rd_idx),
    .rd_o     (rd)
  );

  // shared time unit: elapsed time since the relevant stamp of the scanned channel
  assign elapsed = now_q - (rd_on ? rd.on_stamp : rd.set_stamp);

  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    changed_d    = changed_q;
    last_d       = last_q;
    scan_idx_d   = scan_idx_q;
    scan_off_d   = scan_off_q;
    acc_d        = acc_q;
    now_d        = now_q;
    out_valid_d  = out_valid_q;
    out_acc_d    = out_acc_q;
    out_states_d = out_states_q;
    out_change_d = out_change_q;
    out_last_d   = out_last_q;
    wr           = '0;

    if (out_xfer) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          wr.idx   = in_i.channel;
          wr.stamp = in_i.now_ms;
          acc_d    = 1'b0;
          unique case (action_e'(in_i.action))
            ACT_SET_STATE: begin
              if (ch_ok) begin
                wr.set_we   = 1'b1;
                wr.pend_we  = 1'b1;
                wr.pulse_we = 1'b1;
                if (active_q[ch_idx] != in_i.turn_on) begin
                  wr.on_we  = in_i.turn_on;
                  active_d  = in_i.turn_on ? (active_q | ch_bit) : (active_q & ~ch_bit);
                  changed_d = changed_q | ch_bit;
                  last_d    = in_i.channel;
                  acc_d     = 1'b1;
                end
              end
            end
            ACT_ACTIVATE: begin
              if (ch_ok) begin
                wr.set_we   = 1'b1;
                wr.pend_we  = 1'b1;
                wr.pulse_we = 1'b1;
                wr.pend     = in_i.delay_ms;
                wr.pulse    = (in_i.pulse_ms != '0) ? in_i.pulse_ms : dflt_pulse_q;
                acc_d       = 1'b1;
                if (in_i.delay_ms == '0 && !active_q[ch_idx]) begin
                  wr.on_we  = 1'b1;
                  active_d  = active_q | ch_bit;
                  changed_d = changed_q | ch_bit;
                  last_d    = in_i.channel;
                end
              end
            end
            ACT_CLEAR: begin
              changed_d = '0;
              acc_d     = 1'b1;
            end
            ACT_TICK, ACT_ALL_OFF: begin
              state_d    = ST_SCAN;
              scan_idx_d = '0;
              scan_off_d = (action_e'(in_i.action) == ACT_ALL_OFF);
              now_d      = in_i.now_ms;
            end
            default: ;
          endcase
          if (action_e'(in_i.action) != ACT_TICK && action_e'(in_i.action) != ACT_ALL_OFF) begin
            out_valid_d  = 1'b1;
            out_acc_d    = acc_d;
            out_states_d = STATE_W'(active_d);
            out_change_d = STATE_W'(changed_d);
            out_last_d   = last_d;
          end
        end
      end
      ST_SCAN: begin
        if (scan_idx_q < used_cnt) begin
          wr.idx     = CHAN_W'(scan_idx_q);
          wr.stamp   = now_q;
          scan_idx_d = scan_idx_q + CNT_W'(1);
          if (scan_off_q) begin
            wr.set_we   = 1'b1;
            wr.pend_we  = 1'b1;
            wr.pulse_we = 1'b1;
            if (rd_on) begin
              active_d  = active_q & ~rd_bit;
              changed_d = changed_q | rd_bit;
              last_d    = CHAN_W'(scan_idx_q);
              acc_d     = 1'b1;
            end
          end else if (rd_on) begin
            // pulse or maximum on time expired: one switch-off
            if ((max_on_q != '0 && elapsed > max_on_q) ||
                (rd.pulse != '0 && elapsed > TIME_W'(rd.pulse))) begin
              active_d  = active_q & ~rd_bit;
              changed_d = changed_q | rd_bit;
              last_d    = CHAN_W'(scan_idx_q);
              acc_d     = 1'b1;
            end
          end else if (rd.pend != '0 && elapsed >= TIME_W'(rd.pend)) begin
            wr.on_we   = 1'b1;
            wr.pend_we = 1'b1;
            active_d   = active_q | rd_bit;
            changed_d  = changed_q | rd_bit;
            last_d     = CHAN_W'(scan_idx_q);
            acc_d      = 1'b1;
          end
        end else begin
          state_d      = ST_IDLE;
          out_valid_d  = 1'b1;
          out_acc_d    = acc_q;
          out_states_d = STATE_W'(active_q);
          out_change_d = STATE_W'(changed_q);
          out_last_d   = last_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      changed_q   <= '0;
      last_q      <= '0;
      scan_idx_q  <= '0;
      scan_off_q  <= 1'b0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      changed_q   <= changed_d;
      last_q      <= last_d;
      scan_idx_q  <= scan_idx_d;
      scan_off_q  <= scan_off_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    out_acc_q    <= out_acc_d;
    out_states_q <= out_states_d;
    out_change_q <= out_change_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.accepted     = out_acc_q;
  assign out_o.states       = out_states_q;
  assign out_o.change_bits  = out_change_q;
  assign out_o.last_changed = out_last_q;

endmodule
`default_nettype wire

// ----- hw/rtl/tocb_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tocb_checker
// Port-level checks of the timed output channel bank, bound to the top level.
// ----------------------------------------------------------------------------
module tocb_checker import tocb_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic [ACTION_W-1:0] in_action_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire logic                out_accepted_i,
  input wire logic [STATE_W-1:0]  out_states_i,
  input wire logic [STATE_W-1:0]  out_change_i,
  input wire logic [CHAN_W-1:0]   out_last_i
);

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // one item in flight: no second transfer before the result is out
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("input ready right after an input transfer");

  // exactly one result per item
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |=> !out_valid_i)
    else $error("second result without a new input transfer");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_action_i == ACT_CLEAR) |=>
      (out_valid_i && out_accepted_i && out_change_i == '0))
    else $error("clear_changes result wrong or late");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_accepted_i) && $stable(out_states_i) &&
       $stable(out_change_i) && $stable(out_last_i)))
    else $error("stalled result dropped or changed");

endmodule

bind timed_output_channel_bank_core tocb_checker u_tocb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_action_i    (in_i.action),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_accepted_i (out_o.accepted),
  .out_states_i   (out_o.states),
  .out_change_i   (out_o.change_bits),
  .out_last_i     (out_o.last_changed)
);
`default_nettype wire
